>>> rtl/core/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared opcodes, engine state type and delay helper for the I2C master
// bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DELAY_W = 12;
	localparam int unsigned BITCNT_W = 4;
	localparam int unsigned PHASE_W = 2;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_START = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;
	localparam logic [OP_W-1:0] OP_WACK  = 3'd5;

	localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
	localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
	localparam logic [PHASE_W-1:0] PH_2 = 2'd2;
	localparam logic [PHASE_W-1:0] PH_3 = 2'd3;

	// delay lengths in units
	localparam logic [3:0] UNITS_EDGE = 4'd15;
	localparam logic [3:0] UNITS_ACK  = 4'd4;
	localparam logic [3:0] UNITS_HALF = 4'd2;
	localparam logic [3:0] UNITS_ONE  = 4'd1;

	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [BYTE_W-1:0] TPU_RESET   = 8'd1;
	localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd250;

	localparam logic CFG_TPU   = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]     command;
		logic [PHASE_W-1:0]  phase;
		logic [BITCNT_W-1:0] bit_count;
		logic [BYTE_W-1:0]   shift_reg;
		logic [DELAY_W-1:0]  delay_count;
		logic [BYTE_W-1:0]   poll_count;
		logic                scl;
		logic                sda;
		logic [BYTE_W-1:0]   rx_hold;
		logic                fail;
	} eng_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ticks_per_unit;
		logic [BYTE_W-1:0] ack_poll_limit;
	} eng_cfg_t;

	// units * ticks_per_unit, at most 15 * 255, fits twelve bits
	function automatic logic [DELAY_W-1:0] unit_delay(input logic [3:0] units,
			input logic [BYTE_W-1:0] tpu);
		logic [DELAY_W-1:0] prod;
		prod = DELAY_W'(units) * DELAY_W'(tpu);
		return prod;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/i2cm_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the bit engine: applies one request (command or tick)
// to the current engine state.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::eng_state_t          cur,
	input  i2cm_pkg::eng_cfg_t            cfg,
	input  logic [i2cm_pkg::OP_W-1:0]     opcode,
	input  logic [i2cm_pkg::BYTE_W-1:0]   tx_byte,
	input  logic                          send_ack,
	input  logic                          sda_sample,
	output i2cm_pkg::eng_state_t          nxt,
	output logic                          done
);
	import i2cm_pkg::*;

	logic                is_cmd;
	logic                adv_done;
	logic [BITCNT_W-1:0] bc_inc;

	assign is_cmd = (opcode == OP_START) || (opcode == OP_STOP) || (opcode == OP_WRITE)
		|| (opcode == OP_READ) || (opcode == OP_WACK);
	assign bc_inc = cur.bit_count + BITCNT_W'(1);

	always_comb begin
		nxt = cur;
		done = 1'b0;
		adv_done = 1'b0;
		if (is_cmd) begin
			if (cur.command == OP_TICK) begin
				nxt.command = opcode;
				nxt.phase = PH_0;
				case (opcode)
					OP_START: begin
						nxt.scl = 1'b1;
						nxt.sda = 1'b1;
						nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
					end
					OP_STOP: begin
						nxt.scl = 1'b0;
						nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
					end
					OP_WRITE: begin
						nxt.bit_count = '0;
						nxt.scl = 1'b0;
						nxt.sda = tx_byte[BYTE_W-1];
						nxt.shift_reg = {tx_byte[BYTE_W-2:0], 1'b0};
						nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
					end
					OP_READ: begin
						nxt.sda = 1'b1;
						nxt.scl = 1'b0;
						nxt.shift_reg = '0;
						nxt.bit_count = '0;
						nxt.poll_count = BYTE_W'(send_ack);
						nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
					end
					default: begin
						nxt.fail = 1'b0;
						nxt.sda = 1'b1;
						nxt.delay_count = unit_delay(UNITS_ONE, cfg.ticks_per_unit);
					end
				endcase
			end
		end else if (opcode == OP_TICK && cur.command != OP_TICK) begin
			if (cur.command == OP_WACK && cur.phase == PH_2) begin
				// acknowledge polling, one sample per tick
				if (!sda_sample) begin
					nxt.scl = 1'b0;
					nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
					nxt.phase = PH_3;
				end else if (cur.poll_count >= cfg.ack_poll_limit) begin
					nxt.fail = 1'b1;
					nxt.command = OP_STOP;
					nxt.scl = 1'b0;
					nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
					nxt.phase = PH_0;
				end else begin
					nxt.poll_count = cur.poll_count + BYTE_W'(1);
				end
			end else if (cur.delay_count > DELAY_W'(1)) begin
				nxt.delay_count = cur.delay_count - DELAY_W'(1);
			end else begin
				nxt.delay_count = '0;
				case (cur.command)
					OP_START: begin
						if (cur.phase == PH_0) begin
							nxt.sda = 1'b0;
							nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
							nxt.phase = PH_1;
						end else begin
							nxt.scl = 1'b0;
							adv_done = 1'b1;
						end
					end
					OP_STOP: begin
						case (cur.phase)
							PH_0: begin
								nxt.sda = 1'b0;
								nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
								nxt.phase = PH_1;
							end
							PH_1: begin
								nxt.scl = 1'b1;
								nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
								nxt.phase = PH_2;
							end
							PH_2: begin
								nxt.sda = 1'b1;
								nxt.delay_count = unit_delay(UNITS_EDGE, cfg.ticks_per_unit);
								nxt.phase = PH_3;
							end
							default: begin
								adv_done = 1'b1;
							end
						endcase
					end
					OP_WRITE: begin
						if (cur.phase == PH_0) begin
							nxt.scl = 1'b1;
							nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
							nxt.phase = PH_1;
						end else if (cur.phase == PH_1) begin
							nxt.scl = 1'b0;
							nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
							nxt.phase = PH_2;
						end else begin
							nxt.bit_count = bc_inc;
							if (bc_inc >= BITS_PER_BYTE) begin
								adv_done = 1'b1;
							end else begin
								nxt.sda = cur.shift_reg[BYTE_W-1];
								nxt.shift_reg = {cur.shift_reg[BYTE_W-2:0], 1'b0};
								nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
								nxt.phase = PH_0;
							end
						end
					end
					OP_READ: begin
						case (cur.phase)
							PH_0: begin
								nxt.scl = 1'b1;
								nxt.delay_count = unit_delay(UNITS_ONE, cfg.ticks_per_unit);
								nxt.phase = PH_1;
							end
							PH_1: begin
								// sample at the end of the scl high unit
								nxt.shift_reg = {cur.shift_reg[BYTE_W-2:0], sda_sample};
								nxt.bit_count = bc_inc;
								nxt.scl = 1'b0;
								if (bc_inc < BITS_PER_BYTE) begin
									nxt.delay_count = unit_delay(UNITS_HALF, cfg.ticks_per_unit);
									nxt.phase = PH_0;
								end else begin
									nxt.sda = (cur.poll_count == '0);
									nxt.delay_count = unit_delay(UNITS_ACK, cfg.ticks_per_unit);
									nxt.phase = PH_2;
								end
							end
							PH_2: begin
								nxt.scl = 1'b1;
								nxt.delay_count = unit_delay(UNITS_ACK, cfg.ticks_per_unit);
								nxt.phase = PH_3;
							end
							default: begin
								nxt.scl = 1'b0;
								nxt.sda = 1'b1;
								nxt.rx_hold = cur.shift_reg;
								adv_done = 1'b1;
							end
						endcase
					end
					default: begin
						if (cur.phase == PH_0) begin
							nxt.scl = 1'b1;
							nxt.delay_count = unit_delay(UNITS_ONE, cfg.ticks_per_unit);
							nxt.phase = PH_1;
						end else if (cur.phase == PH_1) begin
							nxt.poll_count = '0;
							nxt.phase = PH_2;
						end else begin
							adv_done = 1'b1;
						end
					end
				endcase
				if (adv_done) begin
					nxt.command = OP_TICK;
					nxt.phase = PH_0;
					nxt.delay_count = '0;
					done = 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/i2c_master_bit_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: start, stop, write byte, read byte and wait-ack
// commands paced by tick requests, open-drain SCL/SDA drive levels out.
// ----------------------------------------------------------------------------
// Every request (command or tick) yields exactly one result carrying the line
// levels, busy/done status, last received byte and the ack failure flag. A
// request is registered on acceptance, and the engine state and the result
// register are updated together from it once the result side is free. One
// request is taken every clock while the result side keeps up; the rate is set
// by the single state update loop. Commands arriving while busy are dropped
// (still answered), opcodes six and seven do nothing. Configuration writes are
// always taken and should happen only while the engine is idle.
module i2c_master_bit_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [i2cm_pkg::OP_W-1:0]   opcode,
	input  logic [i2cm_pkg::BYTE_W-1:0] tx_byte,
	input  logic                        send_ack,
	input  logic                        sda_sample,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        scl_level,
	output logic                        sda_level,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [i2cm_pkg::BYTE_W-1:0] rx_byte,
	output logic                        ack_failed,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [i2cm_pkg::BYTE_W-1:0] cfg_data
);
	import i2cm_pkg::*;

	eng_state_t        st_q;
	eng_state_t        st_nxt;
	eng_cfg_t          cfg_q;
	logic              step_done;

	logic              valid_s1;
	logic [OP_W-1:0]   opcode_s1;
	logic [BYTE_W-1:0] tx_byte_s1;
	logic              send_ack_s1;
	logic              sda_sample_s1;

	logic              out_free;
	logic              fire;

	assign out_free  = !out_valid || out_ready;
	assign fire      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_unit <= TPU_RESET;
			cfg_q.ack_poll_limit <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TPU:   cfg_q.ticks_per_unit <= cfg_data;
				CFG_LIMIT: cfg_q.ack_poll_limit <= cfg_data;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			tx_byte_s1    <= tx_byte;
			send_ack_s1   <= send_ack;
			sda_sample_s1 <= sda_sample;
		end
	end

	i2cm_step u_step (
		.cur        (st_q),
		.cfg        (cfg_q),
		.opcode     (opcode_s1),
		.tx_byte    (tx_byte_s1),
		.send_ack   (send_ack_s1),
		.sda_sample (sda_sample_s1),
		.nxt        (st_nxt),
		.done       (step_done)
	);

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.command     <= OP_TICK;
			st_q.phase       <= PH_0;
			st_q.bit_count   <= '0;
			st_q.shift_reg   <= '0;
			st_q.delay_count <= '0;
			st_q.poll_count  <= '0;
			st_q.scl         <= 1'b1;
			st_q.sda         <= 1'b1;
			st_q.rx_hold     <= '0;
			st_q.fail        <= 1'b0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			scl_level  <= st_nxt.scl;
			sda_level  <= st_nxt.sda;
			busy_res   <= (st_nxt.command != OP_TICK);
			done_res   <= step_done;
			rx_byte    <= st_nxt.rx_hold;
			ack_failed <= st_nxt.fail;
		end
	end

endmodule
`default_nettype wire
